// File: hdl/qspi_nor_flash_command_sequencer_core_assert.svh
// Assertion macros for the quad-SPI NOR flash command sequencer.
// Included by the top level; no other dependencies.
`ifndef QSPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define QSPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define QNFCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QNFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QNFCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define QNFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/qnfcs_pkg.sv
// Shared types and constants of the quad-SPI NOR flash command sequencer.
// No dependencies; used by the front end, the sequencer and the top level.
`timescale 1ns / 1ps
package qnfcs_pkg;

    localparam int ADDR_W = 24;
    localparam int LEN_W  = 25;
    localparam int IDX_W  = 13;
    localparam int REQ_W  = 3;

    localparam logic [LEN_W-1:0] LEN_MAX = 25'h1000000;

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT  = 3'd0,
        REQ_READ  = 3'd1,
        REQ_WRITE = 3'd2,
        REQ_ERASE = 3'd3,
        REQ_STEP  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_RECV = 2'd1,
        KIND_POLL = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    localparam logic [7:0] OP_PAGE_PROGRAM    = 8'h32;
    localparam logic [7:0] OP_FAST_READ       = 8'h0B;
    localparam logic [7:0] OP_READ_STATUS     = 8'h05;
    localparam logic [7:0] OP_WRITE_ENABLE    = 8'h06;
    localparam logic [7:0] OP_SUBSECTOR_ERASE = 8'h20;
    localparam logic [7:0] OP_SECTOR_ERASE    = 8'hD8;
    localparam logic [7:0] OP_BULK_ERASE      = 8'hC7;
    localparam logic [7:0] OP_WRITE_VCR       = 8'h61;
    localparam logic [7:0] VCR_VALUE          = 8'h5F;
    localparam logic [7:0] STATUS_WIP         = 8'h01;
    localparam logic [3:0] READ_DUMMY         = 4'd10;

    typedef struct packed {
        t_req              op;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
        logic              len_zero;
        logic              range_bad;
    } t_cmd;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        opcode;
        logic              has_address;
        logic [ADDR_W-1:0] cmd_address;
        logic [3:0]        dummy_cycles;
        logic              quad_lines;
        logic [ADDR_W-1:0] data_offset;
        logic [LEN_W-1:0]  data_len;
        logic [7:0]        inline_byte;
        logic [7:0]        status_mask;
    } t_frame;

    localparam int CMD_W   = $bits(t_cmd);
    localparam int FRAME_W = $bits(t_frame);

endpackage

// File: hdl/qnfcs_fifo.sv
// Small register queue of fixed-width words, first in first out.
// No dependencies; DEPTH must be at least 2.
`timescale 1ns / 1ps
module qnfcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/qnfcs_front.sv
// Request front end: decodes and checks host words, queues them for the sequencer.
// Depends on qnfcs_pkg and qnfcs_fifo.
`timescale 1ns / 1ps
module qnfcs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [2:0]                  i_req_type,
    input  logic [23:0]                 i_req_address,
    input  logic [24:0]                 i_data_length,
    input  logic [12:0]                 i_begin_index,
    input  logic [12:0]                 i_end_index,
    input  logic [12:0]                 i_nsub,
    input  logic                        i_cmd_pop,
    output qnfcs_pkg::t_cmd             o_cmd,
    output logic                        o_cmd_valid
);
    qnfcs_pkg::t_cmd               w_cmd;
    logic [qnfcs_pkg::CMD_W-1:0]   w_cmd_bits;
    logic                          w_known;
    logic                          w_empty;

    // drop unknown request codes here
    assign w_known = (i_req_type <= qnfcs_pkg::REQ_STEP);

    always_comb begin
        w_cmd.op        = qnfcs_pkg::t_req'(i_req_type);
        w_cmd.address   = i_req_address;
        w_cmd.length    = (i_data_length > qnfcs_pkg::LEN_MAX) ?
                          qnfcs_pkg::LEN_MAX : i_data_length;
        w_cmd.first     = i_begin_index;
        w_cmd.last      = i_end_index;
        w_cmd.len_zero  = (i_data_length == '0);
        w_cmd.range_bad = (i_begin_index >= i_end_index) || (i_end_index > i_nsub);
    end

    qnfcs_fifo #(
        .WIDTH (qnfcs_pkg::CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_known),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_cmd_bits),
        .o_empty (w_empty)
    );

    assign o_cmd       = qnfcs_pkg::t_cmd'(w_cmd_bits);
    assign o_cmd_valid = !w_empty;

endmodule

// File: hdl/qnfcs_back.sv
// Frame sequencer: steps through init, read, write and erase flows, at most one frame per word.
// Depends on qnfcs_pkg.
`timescale 1ns / 1ps
module qnfcs_back #(
    parameter int PAGE_BYTES      = 256,
    parameter int SUBSECTOR_BYTES = 4096,
    parameter int SECTOR_BYTES    = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  qnfcs_pkg::t_cmd     i_cmd,
    output logic                o_cmd_pop,
    input  logic [12:0]         i_nsub,
    input  logic                i_res_full,
    output logic                o_res_push,
    output qnfcs_pkg::t_frame   o_res
);
    localparam int SUB_PER_SEC = SECTOR_BYTES / SUBSECTOR_BYTES;
    localparam int SUB_L       = $clog2(SUBSECTOR_BYTES);
    localparam int MOD_BYTES   = (PAGE_BYTES < SUBSECTOR_BYTES) ? PAGE_BYTES : SUBSECTOR_BYTES;
    localparam logic [12:0] PER_MASK = (SUB_PER_SEC > 0) ? 13'(SUB_PER_SEC - 1) : 13'd0;
    localparam logic [23:0] MOD_MASK = 24'(MOD_BYTES - 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_INIT_WE, PH_INIT_VR, PH_READ, PH_W_WE,
        PH_W_PP, PH_W_POLL, PH_E_WE, PH_E_CMD, PH_E_POLL
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [23:0]         r_cur_addr, n_cur_addr;
    logic [24:0]         r_bytes_left, n_bytes_left;
    logic [23:0]         r_buf_off, n_buf_off;
    logic [12:0]         r_erase_idx, n_erase_idx;
    logic [12:0]         r_erase_end, n_erase_end;

    logic [24:0]         w_room, w_chunk;
    logic [23:0]         w_erase_addr;
    logic                w_bulk, w_sector;
    qnfcs_pkg::t_frame   w_frame, w_we, w_poll, w_done;

    assign o_cmd_pop  = i_cmd_valid && !i_res_full;
    assign o_res      = w_frame;

    assign w_room       = 25'(PAGE_BYTES) - 25'(r_cur_addr & MOD_MASK);
    assign w_chunk      = (r_bytes_left < w_room) ? r_bytes_left : w_room;
    assign w_erase_addr = 24'(r_erase_idx) << SUB_L;
    assign w_bulk       = (r_erase_idx == '0) && (r_erase_end == i_nsub);
    assign w_sector     = (SUB_PER_SEC > 0) && ((r_erase_idx & PER_MASK) == '0) &&
                          (32'(r_erase_idx) + 32'(SUB_PER_SEC) <= 32'(r_erase_end));

    always_comb begin
        w_done      = '0;
        w_done.kind = qnfcs_pkg::KIND_DONE;

        w_we            = '0;
        w_we.kind       = qnfcs_pkg::KIND_CMD;
        w_we.opcode     = qnfcs_pkg::OP_WRITE_ENABLE;
        w_we.quad_lines = 1'b1;

        w_poll             = '0;
        w_poll.kind        = qnfcs_pkg::KIND_POLL;
        w_poll.opcode      = qnfcs_pkg::OP_READ_STATUS;
        w_poll.quad_lines  = 1'b1;
        w_poll.status_mask = qnfcs_pkg::STATUS_WIP;
    end

    always_comb begin
        n_phase      = r_phase;
        n_cur_addr   = r_cur_addr;
        n_bytes_left = r_bytes_left;
        n_buf_off    = r_buf_off;
        n_erase_idx  = r_erase_idx;
        n_erase_end  = r_erase_end;
        o_res_push   = 1'b0;
        w_frame      = w_done;
        if (o_cmd_pop) begin
            if (i_cmd.op == qnfcs_pkg::REQ_STEP) begin
                unique case (r_phase)
                    PH_INIT_WE: begin
                        n_phase             = PH_INIT_VR;
                        o_res_push          = 1'b1;
                        w_frame             = '0;
                        w_frame.kind        = qnfcs_pkg::KIND_CMD;
                        w_frame.opcode      = qnfcs_pkg::OP_WRITE_VCR;
                        w_frame.data_len    = 25'd1;
                        w_frame.inline_byte = qnfcs_pkg::VCR_VALUE;
                    end
                    PH_INIT_VR, PH_READ: begin
                        n_phase    = PH_IDLE;
                        o_res_push = 1'b1;
                    end
                    PH_W_WE: begin
                        n_phase             = PH_W_PP;
                        o_res_push          = 1'b1;
                        w_frame             = '0;
                        w_frame.kind        = qnfcs_pkg::KIND_CMD;
                        w_frame.opcode      = qnfcs_pkg::OP_PAGE_PROGRAM;
                        w_frame.has_address = 1'b1;
                        w_frame.cmd_address = r_cur_addr;
                        w_frame.quad_lines  = 1'b1;
                        w_frame.data_offset = r_buf_off;
                        w_frame.data_len    = w_chunk;
                        n_bytes_left        = r_bytes_left - w_chunk;
                        n_cur_addr          = r_cur_addr + w_chunk[23:0];
                        n_buf_off           = r_buf_off + w_chunk[23:0];
                    end
                    PH_W_PP: begin
                        n_phase    = PH_W_POLL;
                        o_res_push = 1'b1;
                        w_frame    = w_poll;
                    end
                    PH_W_POLL: begin
                        o_res_push = 1'b1;
                        if (r_bytes_left != '0) begin
                            n_phase = PH_W_WE;
                            w_frame = w_we;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_E_WE: begin
                        n_phase            = PH_E_CMD;
                        o_res_push         = 1'b1;
                        w_frame            = '0;
                        w_frame.kind       = qnfcs_pkg::KIND_CMD;
                        w_frame.quad_lines = 1'b1;
                        if (w_bulk) begin
                            w_frame.opcode = qnfcs_pkg::OP_BULK_ERASE;
                            n_erase_idx    = r_erase_end;
                        end else if (w_sector) begin
                            w_frame.opcode      = qnfcs_pkg::OP_SECTOR_ERASE;
                            w_frame.has_address = 1'b1;
                            w_frame.cmd_address = w_erase_addr;
                            n_erase_idx         = r_erase_idx + 13'(SUB_PER_SEC);
                        end else begin
                            w_frame.opcode      = qnfcs_pkg::OP_SUBSECTOR_ERASE;
                            w_frame.has_address = 1'b1;
                            w_frame.cmd_address = w_erase_addr;
                            n_erase_idx         = r_erase_idx + 13'd1;
                        end
                    end
                    PH_E_CMD: begin
                        n_phase    = PH_E_POLL;
                        o_res_push = 1'b1;
                        w_frame    = w_poll;
                    end
                    PH_E_POLL: begin
                        o_res_push = 1'b1;
                        if (r_erase_idx != r_erase_end) begin
                            n_phase = PH_E_WE;
                            w_frame = w_we;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (r_phase == PH_IDLE) begin
                unique case (i_cmd.op)
                    qnfcs_pkg::REQ_INIT: begin
                        n_phase            = PH_INIT_WE;
                        o_res_push         = 1'b1;
                        w_frame            = w_we;
                        w_frame.quad_lines = 1'b0;
                    end
                    qnfcs_pkg::REQ_READ: begin
                        n_phase              = PH_READ;
                        o_res_push           = 1'b1;
                        w_frame              = '0;
                        w_frame.kind         = qnfcs_pkg::KIND_RECV;
                        w_frame.opcode       = qnfcs_pkg::OP_FAST_READ;
                        w_frame.has_address  = 1'b1;
                        w_frame.cmd_address  = i_cmd.address;
                        w_frame.dummy_cycles = qnfcs_pkg::READ_DUMMY;
                        w_frame.quad_lines   = 1'b1;
                        w_frame.data_len     = i_cmd.length;
                    end
                    qnfcs_pkg::REQ_WRITE: begin
                        o_res_push   = 1'b1;
                        n_cur_addr   = i_cmd.address;
                        n_bytes_left = i_cmd.length;
                        n_buf_off    = '0;
                        if (!i_cmd.len_zero) begin
                            n_phase = PH_W_WE;
                            w_frame = w_we;
                        end
                    end
                    qnfcs_pkg::REQ_ERASE: begin
                        o_res_push  = 1'b1;
                        n_erase_end = i_cmd.last;
                        if (i_cmd.range_bad) begin
                            n_erase_idx = i_cmd.last;
                        end else begin
                            n_erase_idx = i_cmd.first;
                            n_phase     = PH_E_WE;
                            w_frame     = w_we;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cur_addr   <= '0;
            r_bytes_left <= '0;
            r_buf_off    <= '0;
            r_erase_idx  <= '0;
            r_erase_end  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_cur_addr   <= n_cur_addr;
            r_bytes_left <= n_bytes_left;
            r_buf_off    <= n_buf_off;
            r_erase_idx  <= n_erase_idx;
            r_erase_end  <= n_erase_end;
        end
    end

endmodule

// File: hdl/qspi_nor_flash_command_sequencer_core.sv
// A frame is written into the output queue in the same cycle as its request word is taken.
// Throughput: one word per cycle while the output queue is not full.
// Two-word queues sit before and after the sequencer; a full output queue stalls it.
// A known word that makes no frame is still popped by the sequencer; unknown codes drop at entry.
// Reset (synchronous, active low): queues empty, sequencer idle, subsector count
// set to 4096 or MAX_SUBSECTORS, whichever is smaller.
`timescale 1ns / 1ps
`include "qspi_nor_flash_command_sequencer_core_assert.svh"
module qspi_nor_flash_command_sequencer_core #(
    parameter int PAGE_BYTES      = 256,
    parameter int SUBSECTOR_BYTES = 4096,
    parameter int SECTOR_BYTES    = 65536,
    parameter int MAX_SUBSECTORS  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_req_type,
    input  logic [23:0] i_req_address,
    input  logic [24:0] i_data_length,
    input  logic [12:0] i_begin_index,
    input  logic [12:0] i_end_index,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_frame_kind,
    output logic [7:0]  o_opcode,
    output logic        o_has_address,
    output logic [23:0] o_cmd_address,
    output logic [3:0]  o_dummy_cycles,
    output logic        o_quad_lines,
    output logic [23:0] o_data_offset,
    output logic [24:0] o_data_len,
    output logic [7:0]  o_inline_byte,
    output logic [7:0]  o_status_mask
);
    localparam logic [12:0] NSUB_RESET =
        13'((MAX_SUBSECTORS < 4096) ? MAX_SUBSECTORS : 4096);

    logic [12:0]                   r_nsub, n_nsub;
    logic                          w_cfg_wr;
    qnfcs_pkg::t_cmd               w_cmd;
    logic                          w_cmd_valid, w_cmd_pop;
    logic                          w_res_full, w_res_push;
    qnfcs_pkg::t_frame             w_res, w_res_out;
    logic [qnfcs_pkg::FRAME_W-1:0] w_res_bits;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {19'd0, r_nsub} : 32'd0;

    // saturate the subsector count
    always_comb begin
        n_nsub = r_nsub;
        if (w_cfg_wr) begin
            n_nsub = (32'(pwdata[12:0]) > MAX_SUBSECTORS) ? 13'(MAX_SUBSECTORS) :
                     pwdata[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsub <= NSUB_RESET;
        end else begin
            r_nsub <= n_nsub;
        end
    end

    qnfcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_req_address (i_req_address),
        .i_data_length (i_data_length),
        .i_begin_index (i_begin_index),
        .i_end_index   (i_end_index),
        .i_nsub        (r_nsub),
        .i_cmd_pop     (w_cmd_pop),
        .o_cmd         (w_cmd),
        .o_cmd_valid   (w_cmd_valid)
    );

    qnfcs_back #(
        .PAGE_BYTES      (PAGE_BYTES),
        .SUBSECTOR_BYTES (SUBSECTOR_BYTES),
        .SECTOR_BYTES    (SECTOR_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_nsub      (r_nsub),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    qnfcs_fifo #(
        .WIDTH (qnfcs_pkg::FRAME_W),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

    assign w_res_out      = qnfcs_pkg::t_frame'(w_res_bits);
    assign o_frame_kind   = w_res_out.kind;
    assign o_opcode       = w_res_out.opcode;
    assign o_has_address  = w_res_out.has_address;
    assign o_cmd_address  = w_res_out.cmd_address;
    assign o_dummy_cycles = w_res_out.dummy_cycles;
    assign o_quad_lines   = w_res_out.quad_lines;
    assign o_data_offset  = w_res_out.data_offset;
    assign o_data_len     = w_res_out.data_len;
    assign o_inline_byte  = w_res_out.inline_byte;
    assign o_status_mask  = w_res_out.status_mask;

    `QNFCS_ASSERT_SAME(a_nsub_range, i_clk, i_rst_n, 1'b1, 32'(r_nsub) <= MAX_SUBSECTORS)
    `QNFCS_ASSERT_SAME(a_res_from_cmd, i_clk, i_rst_n, w_res_push, w_cmd_pop && !w_res_full)
    `QNFCS_ASSERT_NEXT(a_full_needs_push, i_clk, i_rst_n, !full && !push, !full)

endmodule
